FILE: rtl/core/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg: shared types and constants of the open-addressing hash set
// Request and status codes, field widths, hash constants and the command and
// status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package ohs_pkg;

  // Default sizes of the store
  localparam int LOG2_CAPACITY_DEF = 10;
  localparam int KEY_WIDTH_DEF     = 32;

  // Fixed field widths of the ports
  localparam int IN_KEY_W = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int TB_W     = 4;

  // Size register: reset value and lower clamp
  localparam logic [TB_W-1:0] TB_RESET = 4'd10;
  localparam int              TB_MIN   = 3;

  // Hash constants
  localparam int HOME_MULT  = 73;
  localparam int PROBE_STEP = 5009;

  // Slot markers
  localparam int SLOT_EMPTY = 0;
  localparam int SLOT_TOMB  = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TEST   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ABSENT   = 2'd0,
    STAT_DONE     = 2'd1,
    STAT_RESERVED = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take a request word
    logic probe;      // evaluate the slot read last cycle
    logic clr_start;  // load the size register and restart the clearing pass
    logic clr_run;    // write one empty slot of the clearing pass
  } ohs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic imm;        // request resolves without a probe
    logic done;       // probe sequence ends this cycle
    logic clr_last;   // clearing pass is at the last slot
  } ohs_stat_t;

endpackage

FILE: rtl/core/ohs_ram.sv
// ----------------------------------------------------------------------------
// ohs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ohs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ohs_ctrl.sv
// ----------------------------------------------------------------------------
// ohs_ctrl: request sequencer of the hash set
// Runs the clearing pass, takes request words and steps the probe sequence.
// ----------------------------------------------------------------------------
module ohs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cfg_we,
  input  ohs_pkg::ohs_stat_t stat,
  output ohs_pkg::ohs_cmd_t  cmd,
  output logic              busy
);
  import ohs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROBE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.probe     = 1'b0;
    cmd.clr_start = 1'b0;
    cmd.clr_run   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (cfg_we) begin
          cmd.clr_start = 1'b1;
        end else if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_we) begin
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLEAR;
        end else if (start) begin
          cmd.load = 1'b1;
          if (!stat.imm) begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold off requests while working and while a size write lands
  assign busy = (state_r != ST_IDLE) || cfg_we;

  // A probe sequence is never entered for a request that resolves at once
  a_no_probe_after_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && stat.imm) |=> (state_r == ST_IDLE))
    else $error("probe entered for an immediate request");

  // The clearing pass is left only at its last slot
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !cfg_we && !stat.clr_last) |=> (state_r == ST_CLEAR))
    else $error("clearing pass left early");

  // A request word is taken only from idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE && !cfg_we))
    else $error("request word taken outside idle");

endmodule

FILE: rtl/core/ohs_dp.sv
// ----------------------------------------------------------------------------
// ohs_dp: datapath of the hash set
// Slot store, hash and probe address, slot compare, live counter, size
// register, clearing counter and the result word registers.
// ----------------------------------------------------------------------------
module ohs_dp #(
  parameter int LOG2_CAPACITY = ohs_pkg::LOG2_CAPACITY_DEF,
  parameter int KEY_WIDTH     = ohs_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ohs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ohs_pkg::IN_KEY_W-1:0] in_key,
  input  logic [ohs_pkg::TB_W-1:0]     cfg_wdata,
  input  ohs_pkg::ohs_cmd_t            cmd,
  output ohs_pkg::ohs_stat_t           stat,
  output logic                         out_valid,
  output logic [ohs_pkg::STATUS_W-1:0] out_status,
  output logic [ohs_pkg::COUNT_W-1:0]  out_item_count
);
  import ohs_pkg::*;

  localparam int SLOT_W = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
  localparam int AW     = LOG2_CAPACITY;
  localparam int DEPTH  = 1 << AW;
  localparam int LIVE_W = AW + 1;
  localparam int AB_W   = $clog2(AW + 1);

  // Registers
  logic [TB_W-1:0]   tb_r, tb_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] key_r, key_nxt;
  req_t              req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // Combinational signals
  logic [AB_W-1:0]   act_bits;
  logic [AW-1:0]     mask;
  logic [SLOT_W-1:0] key_in;
  logic [AW-1:0]     key_lo;
  logic [AW-1:0]     home;
  logic [AW-1:0]     pos_step;
  req_t              in_req;
  logic              in_reserved;
  status_t           imm_status;
  logic [SLOT_W-1:0] rdata;
  logic              v_empty, v_tomb, v_match, last_probe;
  logic              done, wr_hit, live_up, live_dn;
  status_t           res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata;

  // Clamp the size register and form the slot mask
  always_comb begin
    if (int'(tb_r) < TB_MIN) begin
      act_bits = AB_W'(TB_MIN);
    end else if (int'(tb_r) > AW) begin
      act_bits = AB_W'(AW);
    end else begin
      act_bits = AB_W'(tb_r);
    end
  end

  assign mask = {AW{1'b1}} >> (AB_W'(AW) - act_bits);

  // Home slot of the incoming key and next probe slot
  assign key_in   = SLOT_W'(in_key);
  assign key_lo   = AW'(key_in);
  assign home     = (key_lo * AW'(HOME_MULT)) & mask;
  assign pos_step = (pos_r + AW'(PROBE_STEP)) & mask;

  // Requests that resolve without a probe
  assign in_req      = req_t'(in_req_type);
  assign in_reserved = (key_in == SLOT_W'(SLOT_EMPTY)) || (key_in == SLOT_W'(SLOT_TOMB));
  assign imm_status  = (in_req == REQ_NONE) ? STAT_ABSENT : STAT_RESERVED;

  // Compare the slot read last cycle
  assign v_empty    = (rdata == SLOT_W'(SLOT_EMPTY));
  assign v_tomb     = (rdata == SLOT_W'(SLOT_TOMB));
  assign v_match    = (rdata == key_r);
  assign last_probe = (cnt_r == mask);

  always_comb begin
    done    = 1'b0;
    wr_hit  = 1'b0;
    live_up = 1'b0;
    live_dn = 1'b0;
    res     = STAT_ABSENT;
    if (req_r == REQ_ADD) begin
      if (v_empty || v_tomb) begin
        done    = 1'b1;
        wr_hit  = 1'b1;
        live_up = 1'b1;
        res     = STAT_DONE;
      end else if (v_match) begin
        done = 1'b1;
      end else if (last_probe) begin
        done = 1'b1;
        res  = STAT_FULL;
      end
    end else begin
      if (v_empty) begin
        done = 1'b1;
      end else if (v_match) begin
        done = 1'b1;
        res  = STAT_DONE;
        if (req_r == REQ_REMOVE) begin
          wr_hit  = 1'b1;
          live_dn = 1'b1;
        end
      end else if (last_probe) begin
        done = 1'b1;
      end
    end
  end

  // Slot store ports
  assign ram_we    = cmd.clr_run || (cmd.probe && wr_hit);
  assign ram_waddr = cmd.clr_run ? clr_r : pos_r;
  assign ram_wdata = cmd.clr_run ? SLOT_W'(SLOT_EMPTY) :
                     ((req_r == REQ_ADD) ? key_r : SLOT_W'(SLOT_TOMB));
  assign ram_raddr = cmd.probe ? pos_step : home;

  ohs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Next values
  always_comb begin
    tb_nxt         = tb_r;
    live_nxt       = live_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    req_nxt        = req_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    // Size write: load the register and restart the clearing pass
    if (cmd.clr_start) begin
      tb_nxt   = cfg_wdata;
      live_nxt = '0;
      clr_nxt  = '0;
    end else if (cmd.clr_run) begin
      clr_nxt = clr_r + AW'(1);
    end

    // Take a request word
    if (cmd.load) begin
      key_nxt = key_in;
      req_nxt = in_req;
      pos_nxt = home;
      cnt_nxt = '0;
      if (stat.imm) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = imm_status;
        out_count_nxt  = COUNT_W'(live_r);
      end
    end

    // Advance the probe or finish it
    if (cmd.probe) begin
      if (done) begin
        if (live_up) begin
          live_nxt = live_r + LIVE_W'(1);
        end else if (live_dn && (live_r != '0)) begin
          live_nxt = live_r - LIVE_W'(1);
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = res;
        out_count_nxt  = COUNT_W'(live_nxt);
      end else begin
        pos_nxt = pos_step;
        cnt_nxt = cnt_r + AW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r        <= TB_RESET;
      live_r      <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tb_r        <= tb_nxt;
      live_r      <= live_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign stat.imm      = (in_req == REQ_NONE) || in_reserved;
  assign stat.done     = done;
  assign stat.clr_last = (clr_r == {AW{1'b1}});

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_count = out_count_r;

  // A result word follows only an immediate request or the end of a probe
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past((cmd.load && stat.imm) || (cmd.probe && done)))
    else $error("result word without a finished request");

  // The clearing pass never overlaps request work
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_run |-> !(cmd.probe || cmd.load))
    else $error("clearing pass overlaps a request");

  // The live count moves by at most one per request outside a size write
  a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.clr_start)) |->
      (live_r == $past(live_r) || live_r == $past(live_r) + LIVE_W'(1) ||
       live_r == $past(live_r) - LIVE_W'(1)))
    else $error("live count jumped");

  // The probe counter stays within the active table
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> ((cnt_r & ~mask) == '0))
    else $error("probe count beyond table size");

endmodule

FILE: rtl/core/open_addressing_hash_set_unit.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_set_unit: open-addressing hash set with tombstones
// Adds, removes and tests integer keys in a fixed slot store.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. The probe
// sequence walks the store through its single read port, one slot a cycle,
// and ends at the first decisive slot or after 2^active_bits probes. Reserved
// keys (0, 1) and the unknown request type take no probe. The result word is
// shown on out_status and out_item_count for exactly one cycle, marked by
// out_valid, in the cycle after the request ends; the receiver cannot stall
// it, so it must take every result word when it appears. No new request word
// is taken until the probe sequence of the last one has ended. After reset and
// after each cfg_we write, a clearing pass empties every slot of the store
// while busy stays high; a size write during the pass restarts it.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_unit #(
  parameter int LOG2_CAPACITY = ohs_pkg::LOG2_CAPACITY_DEF,
  parameter int KEY_WIDTH     = ohs_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ohs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ohs_pkg::IN_KEY_W-1:0] in_key,
  output logic                         out_valid,
  output logic [ohs_pkg::STATUS_W-1:0] out_status,
  output logic [ohs_pkg::COUNT_W-1:0]  out_item_count,
  input  logic                         cfg_we,
  input  logic [ohs_pkg::TB_W-1:0]     cfg_wdata
);
  import ohs_pkg::*;

  ohs_cmd_t  cmd;
  ohs_stat_t stat;

  // Sequencer
  ohs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Store and datapath
  ohs_dp #(
    .LOG2_CAPACITY (LOG2_CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_item_count (out_item_count)
  );

endmodule

FILE: dv/hash_set_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_set_checker: result checker of the open-addressing hash set
// Watches the request, result and size-register ports, keeps its own copy of
// the slot store and counters, predicts status and item count for every
// accepted request word and compares each result word with the oldest one.
// ----------------------------------------------------------------------------
module hash_set_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [ohs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ohs_pkg::IN_KEY_W-1:0] in_key,
  input  logic                         out_valid,
  input  logic [ohs_pkg::STATUS_W-1:0] out_status,
  input  logic [ohs_pkg::COUNT_W-1:0]  out_item_count,
  input  logic                         cfg_we,
  input  logic [ohs_pkg::TB_W-1:0]     cfg_wdata,
  input  logic                         end_of_run,
  output int                           mismatch_count
);
  import ohs_pkg::*;

  localparam int STORE_SLOTS = 1 << LOG2_CAPACITY_DEF;

  typedef struct {
    req_t                 req;
    logic [IN_KEY_W-1:0]  key;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } set_reply_t;

  // Shadow copy of the store and its counters
  logic [IN_KEY_W-1:0] model_slots [STORE_SLOTS];
  logic [COUNT_W-1:0]  model_live;
  logic [COUNT_W-1:0]  model_tombs;
  logic [TB_W-1:0]     model_bits;

  set_reply_t replies_due [$];
  bit         tail_checked = 1'b0;

  initial mismatch_count = 0;

  // Print one line and count
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Empty every slot and load a new size setting
  task automatic clear_model(input logic [TB_W-1:0] bits);
    model_bits = bits;
    foreach (model_slots[i]) model_slots[i] = SLOT_EMPTY;
    model_live  = '0;
    model_tombs = '0;
  endtask

  // Apply one request to the shadow store and return its status
  task automatic apply_set_request(input req_t req, input logic [IN_KEY_W-1:0] key,
                                   output status_t status);
    int unsigned         eff;
    int unsigned         mask;
    int unsigned         pos;
    logic [IN_KEY_W-1:0] held;
    eff = model_bits;
    if (eff < TB_MIN) eff = TB_MIN;
    if (eff > LOG2_CAPACITY_DEF) eff = LOG2_CAPACITY_DEF;
    mask   = (1 << eff) - 1;
    pos    = (key * HOME_MULT) & mask;
    status = STAT_ABSENT;
    if (req == REQ_NONE) begin
      status = STAT_ABSENT;
    end else if (key == SLOT_EMPTY || key == SLOT_TOMB) begin
      status = STAT_RESERVED;
    end else if (req == REQ_ADD) begin
      // Take the first empty or deleted slot; a match means already present
      status = STAT_FULL;
      for (int n = 0; n <= mask; n++) begin
        held = model_slots[pos];
        if (held == SLOT_EMPTY || held == SLOT_TOMB) begin
          if (held == SLOT_TOMB && model_tombs != 0) model_tombs--;
          model_slots[pos] = key;
          model_live++;
          status = STAT_DONE;
          break;
        end
        if (held == key) begin
          status = STAT_ABSENT;
          break;
        end
        pos = (pos + PROBE_STEP) & mask;
      end
    end else begin
      // Walk until an empty slot, a match or the probe bound
      for (int n = 0; n <= mask; n++) begin
        held = model_slots[pos];
        if (held == SLOT_EMPTY) break;
        if (held == key) begin
          if (req == REQ_REMOVE) begin
            model_slots[pos] = SLOT_TOMB;
            if (model_live != 0) model_live--;
            model_tombs++;
          end
          status = STAT_DONE;
          break;
        end
        pos = (pos + PROBE_STEP) & mask;
      end
    end
  endtask

  always @(posedge clk) begin
    set_reply_t due;
    status_t    st;
    req_t       req;
    if (!rst_n) begin
      clear_model(TB_RESET);
      replies_due.delete();
    end else begin
      // Compare the result word with the oldest prediction
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: status %0d count %0d",
                                    out_status, out_item_count));
        end else begin
          due = replies_due.pop_front();
          if (out_status !== due.status) begin
            report_mismatch($sformatf("%s key %h: status %0d, want %0d",
                                      due.req.name(), due.key, out_status, due.status));
          end
          if (out_item_count !== due.count) begin
            report_mismatch($sformatf("%s key %h: item count %0d, want %0d",
                                      due.req.name(), due.key, out_item_count, due.count));
          end
        end
      end
      // A size write clears the store
      if (cfg_we) clear_model(cfg_wdata);
      // Predict the accepted request word
      if (start && !busy) begin
        req = req_t'(in_req_type);
        apply_set_request(req, in_key, st);
        due.req    = req;
        due.key    = in_key;
        due.status = st;
        due.count  = model_live;
        replies_due.push_back(due);
      end
      // Flag predictions that never got a result word
      if (end_of_run && !tail_checked) begin
        if (replies_due.size() != 0) begin
          report_mismatch($sformatf("%0d result words never arrived", replies_due.size()));
        end
        tail_checked = 1'b1;
      end
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the open-addressing hash set
// Runs a directed pass over reserved keys, duplicates past a tombstone, a full
// table and the probe bound, then random request words over several size
// settings with random sender gaps. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ohs_pkg::*;

  localparam int STALL_LIMIT     = 10000;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 112;
  localparam int CALM_PHASE      = 3;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [REQ_W-1:0]    in_req_type    = '0;
  logic [IN_KEY_W-1:0] in_key         = '0;
  logic                cfg_we         = 1'b0;
  logic [TB_W-1:0]     cfg_wdata      = '0;
  logic                end_of_run     = 1'b0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_item_count;
  int                  mismatches;

  int words_sent   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  bit calm_sender  = 1'b0;

  // Size settings per phase (clamped ends included) and key pool bounds
  logic [TB_W-1:0] phase_bits [PHASES] = '{4'd15, 4'd0, 4'd5, 4'd10, 4'd4, 4'd7, 4'd3};
  int              phase_pool [PHASES] = '{96, 20, 60, 96, 30, 96, 14};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  open_addressing_hash_set_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_item_count (out_item_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  hash_set_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_item_count (out_item_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .end_of_run     (end_of_run),
    .mismatch_count (mismatches)
  );

  // Count result words
  always @(posedge clk) begin
    if (rst_n && out_valid) results_seen <= results_seen + 1;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request word, hold until taken, then maybe idle
  task automatic send_word(input req_t req, input logic [IN_KEY_W-1:0] key);
    in_req_type <= req;
    in_key      <= key;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
    if (!calm_sender && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Random request word; keys mostly from a small pool so they collide and repeat
  task automatic send_random(input int pool_hi);
    int                  r;
    req_t                req;
    logic [IN_KEY_W-1:0] key;
    r = $urandom_range(99);
    if (r < 4)       req = REQ_NONE;
    else if (r < 46) req = REQ_ADD;
    else if (r < 68) req = REQ_REMOVE;
    else             req = REQ_TEST;
    r = $urandom_range(99);
    if (r < 4)       key = $urandom_range(1, 0);
    else if (r < 16) key = $urandom();
    else             key = $urandom_range(pool_hi, 2);
    send_word(req, key);
  endtask

  // Drop start and wait until every result word is back
  task automatic drain_replies();
    start <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the size register while idle
  task automatic write_size(input logic [TB_W-1:0] bits);
    cfg_wdata <= bits;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size
    send_word(REQ_ADD, 32'd5);
    send_word(REQ_TEST, 32'd5);
    drain_replies();

    // Directed pass on the smallest table
    write_size(4'd3);
    send_word(REQ_ADD, 32'd0);
    send_word(REQ_TEST, 32'd1);
    send_word(REQ_REMOVE, 32'd0);
    send_word(REQ_NONE, 32'd5);
    send_word(REQ_ADD, 32'hFFFF_FFFF);
    send_word(REQ_ADD, 32'd16);
    send_word(REQ_ADD, 32'd24);
    send_word(REQ_ADD, 32'd24);
    send_word(REQ_REMOVE, 32'd16);
    send_word(REQ_TEST, 32'd16);
    // Same home slot: the add lands on the tombstone and stores a second copy
    send_word(REQ_ADD, 32'd24);
    send_word(REQ_REMOVE, 32'd24);
    send_word(REQ_TEST, 32'd24);
    // Fill up, then overflow
    for (int i = 0; i < 9; i++) send_word(REQ_ADD, 32'd2 + i);
    // No empty slot left: lookups stop at the probe bound
    send_word(REQ_TEST, 32'd11);
    send_word(REQ_REMOVE, 32'd11);
    drain_replies();

    // Random phases over several sizes
    for (int p = 0; p < PHASES; p++) begin
      write_size(phase_bits[p]);
      calm_sender = (p == CALM_PHASE);
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_random(phase_pool[p]);
      drain_replies();
    end

    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ohs_pkg.sv
rtl/core/ohs_ram.sv
rtl/core/ohs_ctrl.sv
rtl/core/ohs_dp.sv
rtl/core/open_addressing_hash_set_unit.sv
dv/hash_set_checker.sv
dv/testbench.sv
